@@ hw/rtl/twes_pkg.sv @@
// Shared constants for the timed window event scheduler.
package twes_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int TIME_W     = 32;
  localparam int ID_W       = 32;
  localparam int KIND_W     = 3;
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 64;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_START     = 3'd0;
  localparam kind_t KIND_END       = 3'd1;
  localparam kind_t KIND_ACCEPT    = 3'd2;
  localparam kind_t KIND_BAD_ORDER = 3'd3;
  localparam kind_t KIND_FULL      = 3'd4;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

endpackage

@@ hw/rtl/timed_window_event_scheduler.sv @@
// Timed window event scheduler: window table with one-slot-per-cycle search.
//
// Input stream (in_*): in_tuser is the opcode (add or tick); in_tdata carries
// window_id, open_time, close_time and now_time. One request is taken at a time;
// in_tready is high only while the block is idle.
// Output stream (out_*): out_tuser is the event kind, out_tdata the window id
// and event time, out_tlast marks the final result of one request.
// An add gives its one result through the ST_ADD state, which loads it into
// the output register once the receiver has freed it. A tick runs repeated
// search passes over the table; each pass reads one slot per cycle through
// the single read port of the slot memory. A quiet tick gives no result at all.
// Every tick result waits in a one-entry hold register until the next one is
// found, so tlast can be set on the final one.
// Reset (rst_n low, synchronous) empties the table and clears the insertion
// counter; no clearing pass is needed.
// When the receiver stalls, the search halts before the next result would
// overwrite the output register and resumes when it drains.
module timed_window_event_scheduler
  import twes_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [31:0] window_id, [63:32] open_time, [95:64] close_time, [127:96] now_time
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] opcode
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [31:0] event_id, [63:32] event_time
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [2:0] event_kind
  output logic [KIND_W-1:0]     out_tuser,
  output logic                  out_tlast
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADD  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_RES  = 2'd3;

  // control state
  logic [1:0]          state_r, state_nxt;
  logic                phase_r, phase_nxt;       // 0 start pass, 1 end pass
  logic                iss_r, iss_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic                best_found_r, best_found_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [CAPACITY-1:0] started_r, started_nxt;
  logic [TIME_W-1:0]   ins_cnt_r, ins_cnt_nxt;
  logic [IDX_W-1:0]    scan_idx_r, scan_idx_nxt;

  // payload
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [TIME_W-1:0]   beg_r, beg_nxt;
  logic [TIME_W-1:0]   fin_r, fin_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]    best_idx_r, best_idx_nxt;
  logic [TIME_W-1:0]   best_key_r, best_key_nxt;
  logic [TIME_W-1:0]   best_ord_r, best_ord_nxt;
  logic [ID_W-1:0]     best_id_r, best_id_nxt;
  logic [ID_W-1:0]     pend_id_r, pend_id_nxt;
  kind_t               pend_kind_r, pend_kind_nxt;
  kind_t               out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic [TIME_W-1:0]   out_time_r, out_time_nxt;
  logic                out_last_r, out_last_nxt;

  // slot memory
  logic [ID_W-1:0]     id_mem  [CAPACITY];
  logic [TIME_W-1:0]   beg_mem [CAPACITY];
  logic [TIME_W-1:0]   fin_mem [CAPACITY];
  logic [TIME_W-1:0]   ord_mem [CAPACITY];
  logic [ID_W-1:0]     rd_id_r;
  logic [TIME_W-1:0]   rd_beg_r;
  logic [TIME_W-1:0]   rd_fin_r;
  logic [TIME_W-1:0]   rd_ord_r;
  logic                mem_we;

  logic                free_any;
  logic [IDX_W-1:0]    free_idx;
  logic                out_free;
  logic                bad_order;
  logic                add_ok;
  logic [TIME_W-1:0]   rd_key;
  logic                elig;
  logic                better;
  logic                res_go;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_time_r, out_id_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  assign out_free  = !out_valid_r || out_tready;
  assign bad_order = (beg_r >= fin_r);
  assign add_ok    = !bad_order && free_any;
  assign mem_we    = (state_r == ST_ADD) && out_free && add_ok;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_idx = IDX_W'(i);
    end
    free_any = ~&valid_r;
  end

  // shared compare unit for the slot search
  assign rd_key = phase_r ? rd_fin_r : rd_beg_r;
  assign elig   = valid_r[rd_idx_r] && (phase_r || !started_r[rd_idx_r]) &&
                  (rd_key <= now_r);
  assign better = !best_found_r || (rd_key < best_key_r) ||
                  ((rd_key == best_key_r) && (rd_ord_r < best_ord_r));

  // a found window may be committed once the hold register can be emptied
  assign res_go = best_found_r && (!pend_vld_r || out_free);

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    iss_nxt        = iss_r;
    rd_vld_nxt     = iss_r && (state_r == ST_SCAN);
    best_found_nxt = best_found_r;
    pend_vld_nxt   = pend_vld_r;
    out_valid_nxt  = out_valid_r;
    valid_nxt      = valid_r;
    started_nxt    = started_r;
    ins_cnt_nxt    = ins_cnt_r;
    scan_idx_nxt   = scan_idx_r;
    id_nxt         = id_r;
    beg_nxt        = beg_r;
    fin_nxt        = fin_r;
    now_nxt        = now_r;
    rd_idx_nxt     = scan_idx_r;
    best_idx_nxt   = best_idx_r;
    best_key_nxt   = best_key_r;
    best_ord_nxt   = best_ord_r;
    best_id_nxt    = best_id_r;
    pend_id_nxt    = pend_id_r;
    pend_kind_nxt  = pend_kind_r;
    out_kind_nxt   = out_kind_r;
    out_id_nxt     = out_id_r;
    out_time_nxt   = out_time_r;
    out_last_nxt   = out_last_r;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          id_nxt  = in_tdata[31:0];
          beg_nxt = in_tdata[63:32];
          fin_nxt = in_tdata[95:64];
          now_nxt = in_tdata[127:96];
          if (in_tuser == OP_TICK) begin
            state_nxt      = ST_SCAN;
            phase_nxt      = 1'b0;
            scan_idx_nxt   = '0;
            iss_nxt        = 1'b1;
            best_found_nxt = 1'b0;
            pend_vld_nxt   = 1'b0;
          end else begin
            state_nxt = ST_ADD;
          end
        end
      end
      ST_ADD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_id_nxt    = id_r;
          out_time_nxt  = '0;
          if (bad_order) begin
            out_kind_nxt = KIND_BAD_ORDER;
          end else if (!free_any) begin
            out_kind_nxt = KIND_FULL;
          end else begin
            out_kind_nxt          = KIND_ACCEPT;
            valid_nxt[free_idx]   = 1'b1;
            started_nxt[free_idx] = 1'b0;
            ins_cnt_nxt           = ins_cnt_r + 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (iss_r) begin
          if (scan_idx_r == LAST_IDX) iss_nxt = 1'b0;
          else scan_idx_nxt = scan_idx_r + 1'b1;
        end
        if (rd_vld_r && elig && better) begin
          best_found_nxt = 1'b1;
          best_idx_nxt   = rd_idx_r;
          best_key_nxt   = rd_key;
          best_ord_nxt   = rd_ord_r;
          best_id_nxt    = rd_id_r;
        end
        if (rd_vld_r && (rd_idx_r == LAST_IDX)) state_nxt = ST_RES;
      end
      ST_RES: begin
        if (best_found_r) begin
          if (res_go) begin
            if (pend_vld_r) begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b0;
              out_kind_nxt  = pend_kind_r;
              out_id_nxt    = pend_id_r;
              out_time_nxt  = now_r;
            end
            pend_vld_nxt  = 1'b1;
            pend_id_nxt   = best_id_r;
            pend_kind_nxt = phase_r ? KIND_END : KIND_START;
            if (phase_r) begin
              valid_nxt[best_idx_r]   = 1'b0;
              started_nxt[best_idx_r] = 1'b0;
            end else begin
              started_nxt[best_idx_r] = 1'b1;
            end
            state_nxt      = ST_SCAN;
            scan_idx_nxt   = '0;
            iss_nxt        = 1'b1;
            best_found_nxt = 1'b0;
          end
        end else if (!phase_r) begin
          phase_nxt    = 1'b1;
          state_nxt    = ST_SCAN;
          scan_idx_nxt = '0;
          iss_nxt      = 1'b1;
        end else if (!pend_vld_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_kind_nxt  = pend_kind_r;
          out_id_nxt    = pend_id_r;
          out_time_nxt  = now_r;
          pend_vld_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= 1'b0;
      iss_r        <= 1'b0;
      rd_vld_r     <= 1'b0;
      best_found_r <= 1'b0;
      pend_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      valid_r      <= '0;
      started_r    <= '0;
      ins_cnt_r    <= '0;
      scan_idx_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      iss_r        <= iss_nxt;
      rd_vld_r     <= rd_vld_nxt;
      best_found_r <= best_found_nxt;
      pend_vld_r   <= pend_vld_nxt;
      out_valid_r  <= out_valid_nxt;
      valid_r      <= valid_nxt;
      started_r    <= started_nxt;
      ins_cnt_r    <= ins_cnt_nxt;
      scan_idx_r   <= scan_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r        <= id_nxt;
    beg_r       <= beg_nxt;
    fin_r       <= fin_nxt;
    now_r       <= now_nxt;
    rd_idx_r    <= rd_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_key_r  <= best_key_nxt;
    best_ord_r  <= best_ord_nxt;
    best_id_r   <= best_id_nxt;
    pend_id_r   <= pend_id_nxt;
    pend_kind_r <= pend_kind_nxt;
    out_kind_r  <= out_kind_nxt;
    out_id_r    <= out_id_nxt;
    out_time_r  <= out_time_nxt;
    out_last_r  <= out_last_nxt;
  end

  // slot memory: one write port for adds, one registered read port for the search
  always_ff @(posedge clk) begin
    if (mem_we) begin
      id_mem[free_idx]  <= id_r;
      beg_mem[free_idx] <= beg_r;
      fin_mem[free_idx] <= fin_r;
      ord_mem[free_idx] <= ins_cnt_r;
    end
    rd_id_r  <= id_mem[scan_idx_r];
    rd_beg_r <= beg_mem[scan_idx_r];
    rd_fin_r <= fin_mem[scan_idx_r];
    rd_ord_r <= ord_mem[scan_idx_r];
  end

  a_started_in_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (started_r & ~valid_r) == '0)
    else $error("started flag set on an empty slot");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_vld_r)
    else $error("held result left behind at end of tick");

  a_read_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> state_r == ST_SCAN)
    else $error("slot read returned outside a search pass");

  a_add_fills_slot: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> $countones(valid_r) == $past($countones(valid_r)) + 1)
    else $error("accepted add did not occupy exactly one slot");

  a_end_frees_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RES) && res_go && phase_r |=> !valid_r[$past(best_idx_r)])
    else $error("ended window still holds its slot");

endmodule
